>>> rtl/scd_pkg.sv
package scd_pkg;

    // sample and moving-average window
    localparam int SAMPLE_W  = 10;
    localparam int AVG_DEPTH = 16;                    // power of two: mean is a shift
    localparam int AVG_IDX_W = $clog2(AVG_DEPTH);
    localparam int SUM_W     = SAMPLE_W + AVG_IDX_W;

    // step time history
    localparam int CAD_DEPTH  = 8;
    localparam int CAD_SLOT_W = $clog2(CAD_DEPTH);
    localparam int FILL_W     = 4;
    localparam int FILL_MAX   = 15;
    localparam int TIME_W     = 32;

    // register and field widths
    localparam int THR_W    = 8;
    localparam int CONFIRM_W = 4;
    localparam int REFR_W   = 8;
    localparam int CAD_W    = 10;
    localparam int GAP_W    = 8;
    localparam int TPM_W    = 16;
    localparam int CONF_W   = 8;
    localparam int TOTAL_W  = 16;
    localparam int DECAY_W  = 4;

    // serial divider: numerator is (steps - 1) * ticks_per_minute
    localparam int CAD_NUM_W = CAD_SLOT_W + TPM_W;
    localparam int DIV_CNT_W = $clog2(CAD_NUM_W);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_DROP          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_FALLS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CADENCE_CEILING    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MINUTE   = 3'd6;

    // register reset values
    localparam logic [THR_W-1:0]     RST_THRESHOLD_OFFSET   = 8'd6;
    localparam logic [THR_W-1:0]     RST_FALL_DROP          = 8'd4;
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM_FALLS      = 4'd2;
    localparam logic [REFR_W-1:0]    RST_REFRACTORY_SAMPLES = 8'd25;
    localparam logic [CAD_W-1:0]     RST_CADENCE_CEILING    = 10'd240;
    localparam logic [GAP_W-1:0]     RST_GAP_LIMIT          = 8'd200;
    localparam logic [TPM_W-1:0]     RST_TICKS_PER_MINUTE   = 16'd6000;

    // detector modes
    localparam logic [1:0] MODE_TRACK   = 2'd0;
    localparam logic [1:0] MODE_RISE    = 2'd1;
    localparam logic [1:0] MODE_FALL    = 2'd2;
    localparam logic [1:0] MODE_REFRACT = 2'd3;

endpackage

>>> rtl/step_cadence_detector.sv
// Step and cadence detector. One result beat per sample beat. Once two step times are
// stored, a sample goes from acceptance to its result through these steps: update the
// detector (the averaging window entry is read as the sample is accepted), read the
// oldest stored step time, form the interval, run the bit-serial divider (one quotient
// bit per cycle) that computes steps per minute, and load the output register. The next
// sample is accepted only after that, so samples are handled one at a time. With fewer
// than two stored steps the divider is skipped. The finished result sits in an output
// register, so one waiting result does not stall input; a second finished result waits
// until the first is taken. Configuration writes go straight to the registers: one made
// while idle takes effect on the next sample, one made while a sample is in flight may
// affect that sample. Configuration writes should be done while no sample is in flight.
module step_cadence_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [scd_pkg::SAMPLE_W-1:0]        motion_magnitude,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [scd_pkg::CAD_W-1:0]           cadence_spm,
    output logic [scd_pkg::TOTAL_W-1:0]         steps_total,
    output logic [scd_pkg::CONF_W-1:0]          signal_confidence,
    output logic                                step_pulse
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_SPAN = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // configuration
    logic [scd_pkg::THR_W-1:0]     thr_off_reg;
    logic [scd_pkg::THR_W-1:0]     fall_drop_reg;
    logic [scd_pkg::CONFIRM_W-1:0] confirm_reg;
    logic [scd_pkg::REFR_W-1:0]    refract_reg;
    logic [scd_pkg::CAD_W-1:0]     ceiling_reg;
    logic [scd_pkg::GAP_W-1:0]     gap_limit_reg;
    logic [scd_pkg::TPM_W-1:0]     tpm_reg;

    // sequencing
    logic [2:0] state_reg, state_next;

    // memories
    logic [scd_pkg::SAMPLE_W-1:0] window_mem [scd_pkg::AVG_DEPTH];
    logic [scd_pkg::TIME_W-1:0]   time_mem   [scd_pkg::CAD_DEPTH];

    // detector state
    logic [scd_pkg::SAMPLE_W-1:0]  x_reg;
    logic [scd_pkg::SAMPLE_W-1:0]  win_old_reg;
    logic [scd_pkg::AVG_IDX_W-1:0] win_idx_reg, win_idx_next;
    logic [scd_pkg::SUM_W-1:0]     win_sum_reg, win_sum_next;
    logic                          win_full_reg, win_full_next;
    logic [scd_pkg::SAMPLE_W-1:0]  extreme_reg, extreme_next;
    logic [scd_pkg::SAMPLE_W-1:0]  peak_reg, peak_next;
    logic [scd_pkg::CONFIRM_W-1:0] falls_reg, falls_next;
    logic [scd_pkg::REFR_W-1:0]    left_reg, left_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [scd_pkg::CAD_SLOT_W-1:0] slot_reg, slot_next;
    logic [scd_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [scd_pkg::TIME_W-1:0]    sample_cnt_reg, sample_cnt_next;
    logic [scd_pkg::TIME_W-1:0]    last_time_reg, last_time_next;
    logic [scd_pkg::DECAY_W-1:0]   decay_reg, decay_next;
    logic [scd_pkg::CONF_W-1:0]    conf_reg, conf_next;
    logic [scd_pkg::GAP_W-1:0]     gap_reg, gap_next;
    logic [scd_pkg::CAD_W-1:0]     cadence_reg, cadence_next;
    logic [scd_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic                          pulse_reg, pulse_next;
    logic                          step_hit;

    // interval and divider
    logic [scd_pkg::TIME_W-1:0]    time_rd_reg;
    logic [scd_pkg::CAD_SLOT_W-1:0] time_rd_addr;
    logic [scd_pkg::TIME_W-1:0]    span;
    logic [scd_pkg::CAD_SLOT_W-1:0] steps_m1;
    logic                          den_big_reg, den_big_next;
    logic [scd_pkg::CAD_NUM_W-1:0] den_lo_reg, den_lo_next;
    logic [scd_pkg::CAD_NUM_W-1:0] num_reg, num_next;
    logic [scd_pkg::CAD_NUM_W-1:0] rem_reg, rem_next;
    logic [scd_pkg::CAD_NUM_W-1:0] div_shift;
    logic                          div_fits;
    logic [scd_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [scd_pkg::CAD_W-1:0]     raw_cad;

    // per-sample combinational terms
    logic [scd_pkg::SAMPLE_W-1:0] avg_now;
    logic [scd_pkg::SAMPLE_W:0]   rise_level;
    logic [scd_pkg::SAMPLE_W-1:0] peak_diff;

    // output register
    logic                          out_valid_reg;
    logic [scd_pkg::CAD_W-1:0]     o_cad_reg;
    logic [scd_pkg::TOTAL_W-1:0]   o_total_reg;
    logic [scd_pkg::CONF_W-1:0]    o_conf_reg;
    logic                          o_pulse_reg;
    logic                          out_load;

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign cadence_spm       = o_cad_reg;
    assign steps_total       = o_total_reg;
    assign signal_confidence = o_conf_reg;
    assign step_pulse        = o_pulse_reg;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_off_reg   <= scd_pkg::RST_THRESHOLD_OFFSET;
            fall_drop_reg <= scd_pkg::RST_FALL_DROP;
            confirm_reg   <= scd_pkg::RST_CONFIRM_FALLS;
            refract_reg   <= scd_pkg::RST_REFRACTORY_SAMPLES;
            ceiling_reg   <= scd_pkg::RST_CADENCE_CEILING;
            gap_limit_reg <= scd_pkg::RST_GAP_LIMIT;
            tpm_reg       <= scd_pkg::RST_TICKS_PER_MINUTE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                scd_pkg::REG_THRESHOLD_OFFSET:   thr_off_reg   <= cfg_data[scd_pkg::THR_W-1:0];
                scd_pkg::REG_FALL_DROP:          fall_drop_reg <= cfg_data[scd_pkg::THR_W-1:0];
                scd_pkg::REG_CONFIRM_FALLS:      confirm_reg   <= cfg_data[scd_pkg::CONFIRM_W-1:0];
                scd_pkg::REG_REFRACTORY_SAMPLES: refract_reg   <= cfg_data[scd_pkg::REFR_W-1:0];
                scd_pkg::REG_CADENCE_CEILING:    ceiling_reg   <= cfg_data[scd_pkg::CAD_W-1:0];
                scd_pkg::REG_GAP_LIMIT:          gap_limit_reg <= cfg_data[scd_pkg::GAP_W-1:0];
                scd_pkg::REG_TICKS_PER_MINUTE:   tpm_reg       <= cfg_data[scd_pkg::TPM_W-1:0];
                default:                         ;
            endcase
        end
    end

    // Detector update. The mean only matters once the window is full (a rise needs a
    // full window and every later step comes after a rise), so it is always sum / depth.
    always_comb
    begin
        win_idx_next    = win_idx_reg;
        win_sum_next    = win_sum_reg;
        win_full_next   = win_full_reg;
        extreme_next    = extreme_reg;
        peak_next       = peak_reg;
        falls_next      = falls_reg;
        left_next       = left_reg;
        mode_next       = mode_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        sample_cnt_next = sample_cnt_reg;
        last_time_next  = last_time_reg;
        decay_next      = decay_reg;
        conf_next       = conf_reg;
        gap_next        = gap_reg;
        total_next      = total_reg;
        pulse_next      = pulse_reg;
        step_hit        = 1'b0;
        avg_now         = '0;
        rise_level      = '0;
        peak_diff       = '0;

        if (state_reg == S_CORE)
        begin
            pulse_next      = 1'b0;
            sample_cnt_next = sample_cnt_reg + 1'b1;
            if (gap_reg != {scd_pkg::GAP_W{1'b1}})
                gap_next = gap_reg + 1'b1;

            if (win_full_reg)
                win_sum_next = win_sum_reg - scd_pkg::SUM_W'(win_old_reg)
                               + scd_pkg::SUM_W'(x_reg);
            else
                win_sum_next = win_sum_reg + scd_pkg::SUM_W'(x_reg);
            if (win_idx_reg == scd_pkg::AVG_IDX_W'(scd_pkg::AVG_DEPTH - 1))
            begin
                win_full_next = 1'b1;
                win_idx_next  = '0;
            end
            else
            begin
                win_idx_next = win_idx_reg + 1'b1;
            end
            avg_now    = win_sum_next[scd_pkg::SUM_W-1:scd_pkg::AVG_IDX_W];
            rise_level = {1'b0, avg_now} + (scd_pkg::SAMPLE_W+1)'(thr_off_reg);
            peak_diff  = peak_reg - avg_now;

            if (decay_reg != '0)
            begin
                decay_next = decay_reg - 1'b1;
            end
            else
            begin
                decay_next = {scd_pkg::DECAY_W{1'b1}};
                if (conf_reg != '0)
                    conf_next = conf_reg - 1'b1;
            end

            case (mode_reg)
                scd_pkg::MODE_TRACK:
                begin
                    extreme_next = x_reg;
                    falls_next   = '0;
                    if (win_full_next && ({1'b0, x_reg} > rise_level))
                        mode_next = scd_pkg::MODE_RISE;
                end
                scd_pkg::MODE_RISE:
                begin
                    if (x_reg > extreme_reg)
                    begin
                        extreme_next = x_reg;
                        falls_next   = '0;
                    end
                    else if ((extreme_reg - x_reg) >= scd_pkg::SAMPLE_W'(fall_drop_reg))
                    begin
                        mode_next  = scd_pkg::MODE_FALL;
                        falls_next = scd_pkg::CONFIRM_W'(1);
                        peak_next  = extreme_reg;
                    end
                end
                scd_pkg::MODE_FALL:
                begin
                    extreme_next = x_reg;
                    if (x_reg < extreme_reg)
                    begin
                        if (falls_reg != {scd_pkg::CONFIRM_W{1'b1}})
                            falls_next = falls_reg + 1'b1;
                    end
                    else
                    begin
                        falls_next = scd_pkg::CONFIRM_W'(1);
                    end
                    if (falls_reg >= confirm_reg)
                    begin
                        step_hit       = 1'b1;
                        last_time_next = sample_cnt_next;
                        slot_next      = (slot_reg == scd_pkg::CAD_SLOT_W'(scd_pkg::CAD_DEPTH - 1))
                                         ? '0 : slot_reg + 1'b1;
                        if (fill_reg != scd_pkg::FILL_W'(scd_pkg::FILL_MAX))
                            fill_next = fill_reg + 1'b1;
                        if (total_reg != {scd_pkg::TOTAL_W{1'b1}})
                            total_next = total_reg + 1'b1;
                        pulse_next = 1'b1;
                        gap_next   = '0;
                        if (peak_reg > avg_now)
                            conf_next = (peak_diff[scd_pkg::SAMPLE_W-1:6] != '0)
                                        ? {scd_pkg::CONF_W{1'b1}} : {peak_diff[5:0], 2'b00};
                        else
                            conf_next = '0;
                        decay_next = {scd_pkg::DECAY_W{1'b1}};
                        left_next  = refract_reg;
                        mode_next  = scd_pkg::MODE_REFRACT;
                        falls_next = '0;
                    end
                end
                default:
                begin
                    if (left_reg <= scd_pkg::REFR_W'(1))
                    begin
                        mode_next  = scd_pkg::MODE_TRACK;
                        falls_next = '0;
                    end
                    if (left_reg != '0)
                        left_next = left_reg - 1'b1;
                end
            endcase
        end
    end

    // oldest step time: slot 0 until the history wraps, then the next slot to be written
    assign time_rd_addr = (fill_reg >= scd_pkg::FILL_W'(scd_pkg::CAD_DEPTH)) ? slot_reg : '0;
    assign steps_m1     = (fill_reg >= scd_pkg::FILL_W'(scd_pkg::CAD_DEPTH))
                          ? scd_pkg::CAD_SLOT_W'(scd_pkg::CAD_DEPTH - 1)
                          : fill_reg[scd_pkg::CAD_SLOT_W-1:0] - 1'b1;
    assign span         = last_time_reg - time_rd_reg;

    // restoring divider, one quotient bit per cycle shifted into the numerator register
    assign div_shift = {rem_reg[scd_pkg::CAD_NUM_W-2:0], num_reg[scd_pkg::CAD_NUM_W-1]};
    assign div_fits  = !den_big_reg && (div_shift >= den_lo_reg);

    always_comb
    begin
        den_big_next = den_big_reg;
        den_lo_next  = den_lo_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (state_reg == S_SPAN)
        begin
            if (span == '0)
            begin
                den_big_next = 1'b0;
                den_lo_next  = scd_pkg::CAD_NUM_W'(1);
            end
            else
            begin
                den_big_next = |span[scd_pkg::TIME_W-1:scd_pkg::CAD_NUM_W];
                den_lo_next  = span[scd_pkg::CAD_NUM_W-1:0];
            end
            num_next     = scd_pkg::CAD_NUM_W'(steps_m1) * scd_pkg::CAD_NUM_W'(tpm_reg);
            rem_next     = '0;
            div_cnt_next = '0;
        end
        else if (state_reg == S_DIV)
        begin
            rem_next     = div_fits ? div_shift - den_lo_reg : div_shift;
            num_next     = {num_reg[scd_pkg::CAD_NUM_W-2:0], div_fits};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        raw_cad      = (num_reg > scd_pkg::CAD_NUM_W'(ceiling_reg))
                       ? ceiling_reg : num_reg[scd_pkg::CAD_W-1:0];
        cadence_next = cadence_reg;
        if ((fill_reg >= scd_pkg::FILL_W'(2)) && (raw_cad != '0))
            cadence_next = raw_cad;
        if (gap_reg >= gap_limit_reg)
            cadence_next = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CORE;
            S_CORE:
                state_next = S_READ;
            S_READ:
                state_next = S_SPAN;
            S_SPAN:
                state_next = (fill_reg >= scd_pkg::FILL_W'(2)) ? S_DIV : S_DONE;
            S_DIV:
                if (div_cnt_reg == scd_pkg::DIV_CNT_W'(scd_pkg::CAD_NUM_W - 1))
                    state_next = S_DONE;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            win_idx_reg    <= '0;
            win_sum_reg    <= '0;
            win_full_reg   <= 1'b0;
            extreme_reg    <= '0;
            peak_reg       <= '0;
            falls_reg      <= '0;
            left_reg       <= '0;
            mode_reg       <= scd_pkg::MODE_TRACK;
            slot_reg       <= '0;
            fill_reg       <= '0;
            sample_cnt_reg <= '0;
            decay_reg      <= '0;
            conf_reg       <= '0;
            gap_reg        <= '0;
            cadence_reg    <= '0;
            total_reg      <= '0;
            pulse_reg      <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_idx_reg    <= win_idx_next;
            win_sum_reg    <= win_sum_next;
            win_full_reg   <= win_full_next;
            extreme_reg    <= extreme_next;
            peak_reg       <= peak_next;
            falls_reg      <= falls_next;
            left_reg       <= left_next;
            mode_reg       <= mode_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            sample_cnt_reg <= sample_cnt_next;
            decay_reg      <= decay_next;
            gap_reg        <= gap_next;
            total_reg      <= total_next;
            pulse_reg      <= pulse_next;
            div_cnt_reg    <= div_cnt_next;
            if (out_load)
            begin
                cadence_reg   <= cadence_next;
                conf_reg      <= (gap_reg >= gap_limit_reg) ? '0 : conf_reg;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                conf_reg <= conf_next;
                if (out_ready)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers and memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            x_reg       <= motion_magnitude;
            win_old_reg <= window_mem[win_idx_reg];
        end
        if (state_reg == S_CORE)
            window_mem[win_idx_reg] <= x_reg;
        if (step_hit)
            time_mem[slot_reg] <= sample_cnt_next;
        if (state_reg == S_READ)
            time_rd_reg <= time_mem[time_rd_addr];
        last_time_reg <= last_time_next;
        den_big_reg   <= den_big_next;
        den_lo_reg    <= den_lo_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        if (out_load)
        begin
            o_cad_reg   <= cadence_next;
            o_total_reg <= total_reg;
            o_conf_reg  <= (gap_reg >= gap_limit_reg) ? '0 : conf_reg;
            o_pulse_reg <= pulse_reg;
        end
    end

endmodule
